### design/tle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tle_pkg;

  // Number of characters the edit line can hold.
  localparam int unsigned LineCapacity = 32;
  // Address width of the line store and width of cursor and length.
  localparam int unsigned LineAw = $clog2(LineCapacity);
  localparam int unsigned LineLw = $clog2(LineCapacity + 1);

  // Result kinds.
  localparam logic [1:0] KIND_TERM = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

endpackage

`default_nettype wire

### design/tle_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/terminal_line_editor.sv
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+----------------------------------------
// input     | in        | in_valid_i/in_stall_o | rx_byte_i
// result    | out       | out_valid_o/out_stall_i | out_kind_o, out_byte_o, last_of_run_o
// config    | in        | cfg_we_i            | cfg_wdata_i (echo enable)
//
// One received byte is taken when the block is idle. It then occupies the block
// while it sends its terminal bytes and moves or reads out the line store
// entries that the byte calls for.
// The line store is a single-port-write, registered-read RAM, so every entry
// moved or emitted takes a read state and then a write or send state.
// Reset clears the cursor, length, escape state and sets echo on; the store
// itself is not cleared, since only written entries are ever read.
// A stalled result holds in the output register and pauses the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module terminal_line_editor
  import tle_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [1:0] out_kind_o,
  output logic      [7:0] out_byte_o,
  output logic            last_of_run_o
);

  // Terminal byte codes.
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChDel    = 8'h7F;
  localparam logic [7:0] ChEsc    = 8'h1B;
  localparam logic [7:0] ChCan    = 8'h18;
  localparam logic [7:0] ChLbrack = 8'h5B;
  localparam logic [7:0] ChUp     = 8'h41;
  localparam logic [7:0] ChDown   = 8'h42;
  localparam logic [7:0] ChRight  = 8'h43;
  localparam logic [7:0] ChLeft   = 8'h44;
  localparam logic [7:0] ChOne    = 8'h31;
  localparam logic [7:0] ChTwo    = 8'h32;
  localparam logic [7:0] ChAt     = 8'h40;
  localparam logic [7:0] ChJ      = 8'h4A;

  // Escape parser states; the fourth code behaves as normal mode.
  localparam logic [1:0] EscNormal = 2'd0;
  localparam logic [1:0] EscSeen   = 2'd1;
  localparam logic [1:0] EscCsi    = 2'd2;

  localparam int unsigned PreDepth = 5;
  localparam int unsigned PreW     = $clog2(PreDepth + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_SHR_RD,
    S_SHR_WR,
    S_WRC,
    S_SHL_RD,
    S_SHL_WR,
    S_LINE_RD,
    S_LINE_EMIT,
    S_END
  } state_e;

  // Store work that follows the terminal bytes of one received byte.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INS_SHIFT,
    OP_INS,
    OP_DEL,
    OP_LINE
  } op_e;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic              echo_q, echo_d;
  logic [1:0]        esc_q, esc_d;
  logic [LineLw-1:0] cur_q, cur_d;
  logic [LineLw-1:0] len_q, len_d;
  logic [LineLw-1:0] idx_q, idx_d;
  logic [LineLw-1:0] lim_q, lim_d;
  logic [7:0]        char_q, char_d;
  logic              cr_q, cr_d;
  logic [7:0]        pre_q [PreDepth];
  logic [7:0]        pre_d [PreDepth];
  logic [PreW-1:0]   pre_cnt_q, pre_cnt_d;
  logic [PreW-1:0]   pre_idx_q, pre_idx_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_kind_q, out_kind_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;

  logic              in_accept;
  logic              can_emit;
  logic [LineLw-1:0] idx_m1;
  logic [LineLw-1:0] idx_p1;
  logic [PreW-1:0]   pre_idx_p1;
  logic              ram_we;
  logic [LineAw-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [LineAw-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  // The output register can take a new result when empty or being drained.
  assign can_emit   = !out_valid_q || !out_stall_i;
  assign idx_m1     = idx_q - LineLw'(1);
  assign idx_p1     = idx_q + LineLw'(1);
  assign pre_idx_p1 = pre_idx_q + PreW'(1);

  // The right shift reads the entry below the one it writes; every other
  // walk reads at the index itself, which also holds the read data steady
  // while a line byte waits for the output register.
  assign ram_raddr = (state_q == S_SHR_RD) ? idx_m1[LineAw-1:0] : idx_q[LineAw-1:0];

  tle_ram #(
    .Width (8),
    .Depth (LineCapacity)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    echo_d      = cfg_we_i ? cfg_wdata_i : echo_q;
    esc_d       = esc_q;
    cur_d       = cur_q;
    len_d       = len_q;
    idx_d       = idx_q;
    lim_d       = lim_q;
    char_d      = char_q;
    cr_d        = cr_q;
    pre_d       = pre_q;
    pre_cnt_d   = pre_cnt_q;
    pre_idx_d   = pre_idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[LineAw-1:0];
    ram_wdata   = ram_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          // Decode the byte into a list of terminal bytes and a store walk.
          // Cursor and length move now; the walk keeps the old values in
          // its index and limit registers.
          state_d   = S_PRE;
          pre_idx_d = '0;
          pre_cnt_d = '0;
          char_d    = rx_byte_i;
          cr_d      = 1'b0;
          op_d      = OP_NONE;
          pre_d[0]  = rx_byte_i;
          unique case (esc_q)
            EscSeen: begin
              esc_d     = (rx_byte_i == ChLbrack) ? EscCsi : EscNormal;
              pre_cnt_d = echo_q ? PreW'(1) : '0;
            end
            EscCsi: begin
              esc_d = EscNormal;
              priority if (rx_byte_i == ChUp) begin
                pre_d[0]  = ChOne;
                pre_d[1]  = ChAt;
                pre_cnt_d = PreW'(2);
              end else if (rx_byte_i == ChDown) begin
                pre_d[0]  = ChTwo;
                pre_d[1]  = ChJ;
                pre_cnt_d = PreW'(2);
              end else if (rx_byte_i == ChRight) begin
                if (cur_q < len_q) begin
                  cur_d     = cur_q + LineLw'(1);
                  pre_cnt_d = echo_q ? PreW'(1) : '0;
                end else begin
                  pre_d[0]  = ChCan;
                  pre_cnt_d = PreW'(1);
                end
              end else if (rx_byte_i == ChLeft) begin
                if (cur_q != '0) begin
                  cur_d     = cur_q - LineLw'(1);
                  pre_cnt_d = echo_q ? PreW'(1) : '0;
                end else begin
                  pre_d[0]  = ChCan;
                  pre_cnt_d = PreW'(1);
                end
              end else begin
                pre_cnt_d = echo_q ? PreW'(1) : '0;
              end
            end
            default: begin
              priority if (rx_byte_i == ChLf) begin
                // Line feed is dropped.
              end else if (rx_byte_i == ChCr) begin
                pre_d[0]  = ChLf;
                pre_d[1]  = ChCr;
                pre_cnt_d = echo_q ? PreW'(2) : '0;
                cr_d      = 1'b1;
                op_d      = (len_q != '0) ? OP_LINE : OP_NONE;
                idx_d     = '0;
                lim_d     = len_q;
                cur_d     = '0;
                len_d     = '0;
                esc_d     = EscNormal;
              end else if (rx_byte_i == ChBs || rx_byte_i == ChDel) begin
                if (cur_q != '0) begin
                  // Close the gap only when characters follow the cursor.
                  op_d      = (cur_q < len_q) ? OP_DEL : OP_NONE;
                  idx_d     = cur_q;
                  lim_d     = len_q;
                  cur_d     = cur_q - LineLw'(1);
                  len_d     = len_q - LineLw'(1);
                  pre_cnt_d = (echo_q && rx_byte_i == ChDel) ? PreW'(1) : '0;
                end
              end else if (rx_byte_i == ChEsc) begin
                esc_d     = EscSeen;
                pre_cnt_d = echo_q ? PreW'(1) : '0;
              end else if (len_q < LineLw'(LineCapacity)) begin
                idx_d = len_q;
                lim_d = cur_q;
                cur_d = cur_q + LineLw'(1);
                len_d = len_q + LineLw'(1);
                if (len_q != cur_q) begin
                  // Insert in mid-line: tell the terminal to open a column.
                  op_d      = OP_INS_SHIFT;
                  pre_d[0]  = ChEsc;
                  pre_d[1]  = ChLbrack;
                  pre_d[2]  = ChOne;
                  pre_d[3]  = ChAt;
                  pre_d[4]  = rx_byte_i;
                  pre_cnt_d = echo_q ? PreW'(5) : PreW'(4);
                end else begin
                  op_d      = OP_INS;
                  pre_cnt_d = echo_q ? PreW'(1) : '0;
                end
              end else begin
                // Line full: the byte is dropped.
              end
            end
          endcase
        end
      end

      S_PRE: begin
        if (pre_idx_q != pre_cnt_q) begin
          if (can_emit) begin
            out_valid_d = 1'b1;
            out_kind_d  = KIND_TERM;
            out_byte_d  = pre_q[pre_idx_q[$clog2(PreDepth)-1:0]];
            out_last_d  = (pre_idx_p1 == pre_cnt_q) && !cr_q;
            pre_idx_d   = pre_idx_p1;
          end
        end else begin
          unique case (op_q)
            OP_INS_SHIFT: state_d = S_SHR_RD;
            OP_INS:       state_d = S_WRC;
            OP_DEL:       state_d = S_SHL_RD;
            OP_LINE:      state_d = S_LINE_RD;
            default:      state_d = cr_q ? S_END : S_IDLE;
          endcase
        end
      end

      S_SHR_RD: begin
        state_d = S_SHR_WR;
      end

      S_SHR_WR: begin
        // Move one tail entry up; stop once the cursor slot is free.
        ram_we  = 1'b1;
        idx_d   = idx_m1;
        state_d = (idx_m1 == lim_q) ? S_WRC : S_SHR_RD;
      end

      S_WRC: begin
        ram_we    = 1'b1;
        ram_waddr = lim_q[LineAw-1:0];
        ram_wdata = char_q;
        state_d   = S_IDLE;
      end

      S_SHL_RD: begin
        state_d = S_SHL_WR;
      end

      S_SHL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_m1[LineAw-1:0];
        idx_d     = idx_p1;
        state_d   = (idx_p1 == lim_q) ? S_IDLE : S_SHL_RD;
      end

      S_LINE_RD: begin
        state_d = S_LINE_EMIT;
      end

      S_LINE_EMIT: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_LINE;
          out_byte_d  = ram_rdata;
          out_last_d  = 1'b0;
          idx_d       = idx_p1;
          state_d     = (idx_p1 == lim_q) ? S_END : S_LINE_RD;
        end
      end

      S_END: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_END;
          out_byte_d  = 8'h00;
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NONE;
      echo_q      <= 1'b1;
      esc_q       <= EscNormal;
      cur_q       <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      lim_q       <= '0;
      cr_q        <= 1'b0;
      pre_cnt_q   <= '0;
      pre_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      echo_q      <= echo_d;
      esc_q       <= esc_d;
      cur_q       <= cur_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      lim_q       <= lim_d;
      cr_q        <= cr_d;
      pre_cnt_q   <= pre_cnt_d;
      pre_idx_q   <= pre_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    pre_q      <= pre_d;
    out_kind_q <= out_kind_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

`default_nettype wire

### design/tle_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tle_checker
  import tle_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       cfg_we_i,
  input wire logic       cfg_wdata_i,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] rx_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] out_kind_o,
  input wire logic [7:0] out_byte_o,
  input wire logic       last_of_run_o
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_kind_o)
      && $stable(out_byte_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // The block is busy in the cycle after it accepts a byte.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken back to back");

  // While a run is still open no new byte may be taken.
  a_no_accept_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> in_stall_o)
    else $error("input taken before run ended");

  // The end record is empty and closes its run.
  a_end_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_END |-> out_byte_o == 8'h00 && last_of_run_o)
    else $error("malformed end record");

  // A line byte never closes its run; the end record comes after it.
  a_line_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_LINE |-> !last_of_run_o)
    else $error("line byte closed a run");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (.*);

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps

// Testbench for the terminal line editor.
//
// Bytes are sent to the editor one transfer at a time. At the edge where a
// byte is accepted, a local model of the editor works out every result that
// byte must cause and appends them to a queue. The escape state, cursor,
// length, line contents and echo flag are all tracked in that model. A
// separate process takes each result transfer and compares it, field by
// field, with the oldest queued expectation.
//
// The stimulus starts with a short hand-written editing session: cursor
// moves at both edges, backspace at the line start, a mid-line insert, both
// delete codes, the ignored line feed, the fixed sequences, a broken escape
// sequence and a carriage return. A full-line session follows, with a
// dropped byte and a shift of the whole tail; neither side idles during it.
// Then echo is switched off for a short session, and three random sessions
// run with echo on, off and on.
// The echo register is only written while the editor is idle.
module testbench;
  import tle_pkg::*;

  // Longest wait for the editor to finish a byte that causes no result:
  // a tail shift reads and then writes each entry that it moves.
  localparam int unsigned SettleCycles = 150;
  // The slowest correct run is far below this.
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned IdlePercent  = 6;

  // Control and sequence bytes that the editor reacts to.
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_CAN  = 8'h18;
  localparam logic [7:0] CH_LBR  = "[";
  localparam logic [7:0] CH_UP   = "A";
  localparam logic [7:0] CH_DOWN = "B";
  localparam logic [7:0] CH_RIGHT = "C";
  localparam logic [7:0] CH_LEFT = "D";

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_SEEN,
    ESC_BRACKET
  } esc_mode_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last_run;
  } term_result_t;

  // Every input of the editor holds a known value from time zero.
  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       cfg_we    = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       last_of_run;

  // When calm is set, neither side idles or stalls.
  logic calm = 1'b0;

  // Model of the editor, updated at each accepted transfer.
  esc_mode_e         esc_mode = ESC_NONE;
  logic [LineLw-1:0] cur_pos  = '0;
  logic [LineLw-1:0] line_len = '0;
  logic [7:0]        line_mem [LineCapacity];
  logic              echo_on  = 1'b1;

  term_result_t run_q[$];
  term_result_t term_expected_q[$];
  term_result_t checked_want;

  int unsigned mismatches  = 0;
  int unsigned sent_items  = 0;
  int unsigned cycle_count = 0;

  terminal_line_editor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_kind_o   (out_kind),
    .out_byte_o   (out_byte),
    .last_of_run_o(last_of_run)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // The result side stalls now and then, except during a calm stretch.
  always @(posedge clk_i) begin
    out_stall <= !calm && ($urandom_range(99) < IdlePercent);
  end

  // The run is ended here as failed once the cycle limit is reached.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  function automatic void add_result(input logic [1:0] kind, input logic [7:0] data);
    term_result_t r;
    r.kind     = kind;
    r.data     = data;
    r.last_run = 1'b0;
    run_q.push_back(r);
  endfunction

  // Echoes are the only results that the echo flag suppresses.
  function automatic void echo_result(input logic [7:0] data);
    if (echo_on) begin
      add_result(KIND_TERM, data);
    end
  endfunction

  // Works out the results of one received byte, updates the model state and
  // queues the results. Returns how many results the byte causes.
  function automatic int predict_editor(input logic [7:0] c);
    int i;
    run_q.delete();
    case (esc_mode)
      ESC_SEEN: begin
        // Only '[' opens a sequence; anything else falls back to normal mode.
        esc_mode = (c == CH_LBR) ? ESC_BRACKET : ESC_NONE;
        echo_result(c);
      end
      ESC_BRACKET: begin
        esc_mode = ESC_NONE;
        if (c == CH_UP) begin
          add_result(KIND_TERM, "1");
          add_result(KIND_TERM, "@");
        end else if (c == CH_DOWN) begin
          add_result(KIND_TERM, "2");
          add_result(KIND_TERM, "J");
        end else if (c == CH_RIGHT) begin
          if (cur_pos < line_len) begin
            cur_pos = cur_pos + 1'b1;
            echo_result(c);
          end else begin
            add_result(KIND_TERM, CH_CAN);
          end
        end else if (c == CH_LEFT) begin
          if (cur_pos > 0) begin
            cur_pos = cur_pos - 1'b1;
            echo_result(c);
          end else begin
            add_result(KIND_TERM, CH_CAN);
          end
        end else begin
          echo_result(c);
        end
      end
      default: begin
        if (c == CH_LF) begin
          // A line feed is dropped silently.
        end else if (c == CH_CR) begin
          echo_result(CH_LF);
          echo_result(CH_CR);
          for (i = 0; i < line_len; i++) begin
            add_result(KIND_LINE, line_mem[i]);
          end
          add_result(KIND_END, 8'h00);
          cur_pos  = '0;
          line_len = '0;
        end else if (c == CH_BS || c == CH_DEL) begin
          if (cur_pos != 0) begin
            for (i = cur_pos; i < line_len; i++) begin
              line_mem[i - 1] = line_mem[i];
            end
            cur_pos  = cur_pos - 1'b1;
            line_len = line_len - 1'b1;
            if (c == CH_DEL) begin
              echo_result(c);
            end
          end
        end else if (c == CH_ESC) begin
          esc_mode = ESC_SEEN;
          echo_result(c);
        end else if (line_len < LineCapacity) begin
          // An insert before the end opens a gap on the terminal too.
          if (line_len != cur_pos) begin
            add_result(KIND_TERM, CH_ESC);
            add_result(KIND_TERM, CH_LBR);
            add_result(KIND_TERM, "1");
            add_result(KIND_TERM, "@");
            for (i = line_len; i > cur_pos; i--) begin
              line_mem[i] = line_mem[i - 1];
            end
          end
          line_mem[cur_pos] = c;
          cur_pos  = cur_pos + 1'b1;
          line_len = line_len + 1'b1;
          echo_result(c);
        end
        // A byte arriving on a full line is dropped with no result.
      end
    endcase
    if (run_q.size() > 0) begin
      run_q[run_q.size() - 1].last_run = 1'b1;
    end
    foreach (run_q[k]) begin
      term_expected_q.push_back(run_q[k]);
    end
    return run_q.size();
  endfunction

  // Sends one byte and returns right after the edge at which it was
  // accepted. Valid stays high afterwards, so back-to-back transfers keep it
  // high without a glitch; it is only lowered for an idle gap or a drain.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do begin
      @(posedge clk_i);
    end while (in_stall);
    void'(predict_editor(b));
    sent_items++;
  endtask

  task automatic send_seq(input logic [7:0] final_byte);
    send_byte(CH_ESC);
    send_byte(CH_LBR);
    send_byte(final_byte);
  endtask

  // Waits until every expected result has come, then long enough for a byte
  // without results (a tail shift, for example) to finish as well.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (term_expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_echo(input logic value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    echo_on = value;
    cfg_we <= 1'b0;
  endtask

  // One random editing action. Most actions are typing and well-formed
  // cursor or fixed sequences; the rest are deletes, carriage returns,
  // arbitrary bytes and sequences broken off after ESC or after ESC [.
  task automatic random_action();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      send_byte(8'($urandom_range(126, 32)));
    end else if (pick < 62) begin
      case ($urandom_range(3))
        0: send_seq(CH_UP);
        1: send_seq(CH_DOWN);
        2: send_seq(CH_RIGHT);
        default: send_seq(CH_LEFT);
      endcase
    end else if (pick < 70) begin
      send_byte($urandom_range(1) ? CH_DEL : CH_BS);
    end else if (pick < 74) begin
      send_byte(CH_CR);
    end else if (pick < 86) begin
      send_byte(8'($urandom_range(255)));
    end else if (pick < 92) begin
      send_byte(CH_ESC);
      send_byte(8'($urandom_range(255)));
    end else begin
      send_byte(CH_ESC);
      send_byte(CH_LBR);
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // Hand-written session on the line left empty by reset, echo on.
  task automatic test_directed_editing();
    send_seq(CH_RIGHT);     // cursor already at the line end
    send_seq(CH_LEFT);      // cursor already at the line start
    send_byte(CH_DEL);      // backspace with nothing before the cursor
    send_byte(8'h00);
    send_byte(8'hFF);
    send_seq(CH_LEFT);
    send_byte("x");         // insert in the middle of the line
    send_seq(CH_RIGHT);
    send_byte(CH_DEL);
    send_byte(CH_BS);
    send_byte(CH_LF);
    send_seq(CH_UP);
    send_seq(CH_DOWN);
    send_byte(CH_ESC);      // ESC followed by something other than '['
    send_byte("q");
    send_byte(CH_CR);
  endtask

  // Fills the line, tries one byte too many, then shifts the whole tail with
  // a mid-line insert and reads out a full line. Neither side idles here.
  task automatic test_full_line();
    int i;
    calm = 1'b1;
    for (i = 0; i <= LineCapacity; i++) begin
      send_byte(8'($urandom_range(126, 32)));
    end
    send_seq(CH_LEFT);
    send_seq(CH_LEFT);
    send_byte("z");         // still full, so this one is dropped
    send_byte(CH_BS);
    send_seq(CH_LEFT);
    send_byte("y");
    send_byte(CH_CR);
    calm = 1'b0;
  endtask

  // With echo off only the fixed sequences, cancel bytes and line records come out.
  task automatic test_echo_off();
    write_echo(1'b0);
    send_byte("a");
    send_byte("b");
    send_seq(CH_LEFT);
    send_byte("c");
    send_byte(CH_DEL);
    send_seq(CH_RIGHT);
    send_seq(CH_RIGHT);
    send_seq(CH_UP);
    send_byte(CH_ESC);
    send_byte(CH_CR);
  endtask

  task automatic test_random_editing(input int unsigned n_items, input logic echo_value,
                                     input logic calm_half);
    int unsigned start;
    write_echo(echo_value);
    start = sent_items;
    while (sent_items < start + n_items) begin
      calm = calm_half && (sent_items < start + n_items / 2);
      random_action();
    end
    calm = 1'b0;
  endtask

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (term_expected_q.size() == 0) begin
        if (mismatches < ReportLimit) begin
          $display("unexpected result: kind %0d byte %02h last %0b",
                   out_kind, out_byte, last_of_run);
        end
        mismatches++;
      end else begin
        checked_want = term_expected_q.pop_front();
        if (checked_want.kind !== out_kind || checked_want.data !== out_byte ||
            checked_want.last_run !== last_of_run) begin
          if (mismatches < ReportLimit) begin
            $display({"mismatch: expected kind %0d byte %02h last %0b, ",
                      "got kind %0d byte %02h last %0b"},
                     checked_want.kind, checked_want.data, checked_want.last_run,
                     out_kind, out_byte, last_of_run);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_editing();
    test_full_line();
    test_echo_off();
    test_random_editing(10, 1'b1, 1'b0);
    test_random_editing(10, 1'b0, 1'b0);
    test_random_editing(10, 1'b1, 1'b1);
    wait_idle();
    if (mismatches == 0 && term_expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
design/tle_pkg.sv
design/tle_ram.sv
design/terminal_line_editor.sv
design/tle_checker.sv
sim/testbench.sv
